// ===== sv/qau_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, word types and fixed-point helpers for the quaternion arithmetic unit.
// Depends on nothing; every other file of the unit imports it.
package qau_pkg;

    localparam int FRAC_BITS = 28;

    // Width of a rounded product, of a wide accumulator and of a division numerator.
    localparam int QR_W      = 64 - FRAC_BITS;
    localparam int ACC_W     = QR_W + 3;
    localparam int NUM_W     = (2 * FRAC_BITS > 32) ? (32 + 2 * FRAC_BITS + 1) : 65;

    localparam int SQ_STEPS  = 32;
    localparam int SQ_REM_W  = 34;
    localparam int DIV_STEPS = 32;

    localparam logic [2:0] FUNC_MUL  = 3'd0;
    localparam logic [2:0] FUNC_CONJ = 3'd1;
    localparam logic [2:0] FUNC_NORM = 3'd2;
    localparam logic [2:0] FUNC_INV  = 3'd3;
    localparam logic [2:0] FUNC_ROT  = 3'd4;

    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } qau_in_t;

    typedef struct packed {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic               fault;
    } qau_out_t;

    // Sideband that travels with a word through the square-root pipeline.
    typedef struct packed {
        logic [2:0]       func;
        logic [3:0][31:0] res;
        logic             fault;
        logic [63:0]      s;
        logic [3:0][31:0] mag;
        logic [3:0]       neg;
    } qau_sq_side_t;

    // Sideband that travels with a word through the divider pipeline.
    typedef struct packed {
        logic [2:0]       func;
        logic [3:0][31:0] res;
        logic             fault;
        logic [3:0]       neg;
        logic [3:0]       big;
    } qau_dv_side_t;

    // Product rounded half upwards and scaled back by the fraction bits.
    function automatic logic signed [QR_W-1:0] qround(input logic signed [63:0] p);
        logic signed [63:0] tmp;
        tmp = p + (64'sd1 <<< (FRAC_BITS - 1));
        return $signed(tmp[63:FRAC_BITS]);
    endfunction

    function automatic logic signed [31:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] top;
        top = v[ACC_W-1:31];
        if (top == '0 || top == '1) begin
            return $signed(v[31:0]);
        end
        return v[ACC_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

    function automatic logic signed [31:0] neg_word(input logic signed [31:0] v);
        return (v == WORD_MIN) ? WORD_MAX : -v;
    endfunction

endpackage

// ===== sv/quaternion_arith_unit.sv =====
`timescale 1ns / 1ps
// Quaternion arithmetic unit: multiply, conjugate, normalise, inverse and vector rotation.
// Every operation takes the same path from an accepted word to its result word on m_data;
// output stalls hold it back. Throughput is one word per cycle while the output buffer has room;
// every stage of the 71-stage pipeline moves on together.
// The depth is set by the 32-stage square root followed by the 32-stage divider lanes.
// Reset (aresetn low at a clock edge) empties the pipeline and the output buffer.
module quaternion_arith_unit import qau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  qau_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output qau_out_t m_data
);

    localparam logic [1:0] BUF_FULL = 2'd2;

    logic         adv;
    logic         fr_valid, sq_valid, dv_valid;
    qau_sq_side_t fr_side, sq_side;
    logic [31:0]  sq_root;
    qau_out_t     dv_data;

    logic         push, pop;
    logic [1:0]   count_reg, count_next;
    qau_out_t     head_reg, head_next;
    qau_out_t     tail_reg, tail_next;

    // The whole pipeline advances whenever the two-word output buffer has room. The
    // buffer's fill level is registered, so s_ready does not depend on m_ready, and a
    // result waiting at the output does not stop new words from being accepted.
    assign adv     = (count_reg != BUF_FULL);
    assign s_ready = adv;

    // Products, Hamilton product, conjugate, rotation and the squared magnitude.
    qau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .out_side  (fr_side)
    );

    // Floor square root of the squared magnitude, used by normalise.
    qau_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    // Four divider lanes shared by normalise and inverse, plus the final result select.
    qau_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    // Output buffer: the head word drives m_data, the tail holds a second word while
    // the consumer stalls.
    always_comb begin
        push      = adv && dv_valid;
        pop       = (count_reg != 2'd0) && m_ready;
        head_next = head_reg;
        tail_next = tail_reg;
        case (count_reg)
            2'd0: begin
                if (push) begin
                    head_next = dv_data;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = dv_data;
                end else if (push) begin
                    tail_next = dv_data;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next = tail_reg;
                end
            end
            default: begin
                head_next = head_reg;
            end
        endcase
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = head_reg;

endmodule

// ===== sv/qau_front.sv =====
`timescale 1ns / 1ps
// Five-stage front end: products, Hamilton product, conjugate, rotation and squared magnitude.
// Depends on qau_pkg.
module qau_front import qau_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  logic         in_valid,
    input  qau_in_t      in_data,
    output logic         out_valid,
    output qau_sq_side_t out_side
);

    logic signed [31:0] a_in [4];
    logic signed [31:0] b_in [4];

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [2:0]         func1_reg;
    logic signed [31:0] a1_reg [4];
    logic signed [31:0] b1_reg [4];
    logic signed [63:0] p1_reg [4][4];
    logic signed [63:0] sq1_reg [4];

    qau_sq_side_t       side2_reg, side2_next;
    logic signed [31:0] a2_reg [4];
    logic signed [31:0] b2_reg [3];
    logic signed [31:0] t2_reg [3], t2_next [3];

    qau_sq_side_t       side3_reg, side3_next;
    logic signed [31:0] b3_reg [3];
    logic signed [63:0] pt3_reg [9];

    qau_sq_side_t       side4_reg;
    logic signed [31:0] b4_reg [3];
    logic signed [31:0] x4_reg [3], x4_next [3];
    logic signed [QR_W-1:0] wt4_reg [3], wt4_next [3];

    qau_sq_side_t       side5_reg, side5_next;

    logic signed [QR_W-1:0] rnd [4][4];
    logic signed [QR_W-1:0] prnd [9];
    logic signed [ACC_W-1:0] acc [4];
    logic [64:0]        s_sum;

    assign a_in[0] = in_data.a_w;
    assign a_in[1] = in_data.a_x;
    assign a_in[2] = in_data.a_y;
    assign a_in[3] = in_data.a_z;
    assign b_in[0] = in_data.b_w;
    assign b_in[1] = in_data.b_x;
    assign b_in[2] = in_data.b_y;
    assign b_in[3] = in_data.b_z;

    // Second stage: rounding, sums of products, cross product t and the magnitude.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                rnd[i][j] = qround(p1_reg[i][j]);
            end
        end
        acc[0] = ACC_W'(rnd[0][0]) - ACC_W'(rnd[1][1]) - ACC_W'(rnd[2][2]) - ACC_W'(rnd[3][3]);
        acc[1] = ACC_W'(rnd[0][1]) + ACC_W'(rnd[1][0]) + ACC_W'(rnd[2][3]) - ACC_W'(rnd[3][2]);
        acc[2] = ACC_W'(rnd[0][2]) - ACC_W'(rnd[1][3]) + ACC_W'(rnd[2][0]) + ACC_W'(rnd[3][1]);
        acc[3] = ACC_W'(rnd[0][3]) + ACC_W'(rnd[1][2]) - ACC_W'(rnd[2][1]) + ACC_W'(rnd[3][0]);
        t2_next[0] = sat_word((ACC_W'(rnd[2][3]) - ACC_W'(rnd[3][2])) <<< 1);
        t2_next[1] = sat_word((ACC_W'(rnd[3][1]) - ACC_W'(rnd[1][3])) <<< 1);
        t2_next[2] = sat_word((ACC_W'(rnd[1][2]) - ACC_W'(rnd[2][1])) <<< 1);

        s_sum = 65'($unsigned(sq1_reg[0])) + 65'($unsigned(sq1_reg[1]))
              + 65'($unsigned(sq1_reg[2])) + 65'($unsigned(sq1_reg[3]));

        side2_next       = '0;
        side2_next.func  = func1_reg;
        side2_next.s     = s_sum[64] ? '1 : s_sum[63:0];
        for (int i = 0; i < 4; i++) begin
            side2_next.mag[i] = a1_reg[i][31] ? 32'(-a1_reg[i]) : a1_reg[i];
            if (func1_reg == FUNC_INV && i != 0) begin
                side2_next.neg[i] = !a1_reg[i][31] && (a1_reg[i] != '0);
            end else begin
                side2_next.neg[i] = a1_reg[i][31];
            end
        end
        case (func1_reg)
            FUNC_MUL: begin
                for (int i = 0; i < 4; i++) begin
                    side2_next.res[i] = sat_word(acc[i]);
                end
            end
            FUNC_CONJ: begin
                side2_next.res[0] = a1_reg[0];
                for (int i = 1; i < 4; i++) begin
                    side2_next.res[i] = neg_word(a1_reg[i]);
                end
            end
            default: begin
                side2_next.res = '0;
            end
        endcase
    end

    // Third stage flags a zero magnitude for normalise and inverse.
    always_comb begin
        side3_next = side2_reg;
        side3_next.fault = (side2_reg.func == FUNC_NORM || side2_reg.func == FUNC_INV)
                         && (side2_reg.s == '0);
    end

    // Fourth stage: rounding of the second cross product and of the w * t terms.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            prnd[i] = qround(pt3_reg[i]);
        end
        x4_next[0] = sat_word(ACC_W'(prnd[0]) - ACC_W'(prnd[1]));
        x4_next[1] = sat_word(ACC_W'(prnd[2]) - ACC_W'(prnd[3]));
        x4_next[2] = sat_word(ACC_W'(prnd[4]) - ACC_W'(prnd[5]));
        for (int i = 0; i < 3; i++) begin
            wt4_next[i] = prnd[6 + i];
        end
    end

    // Fifth stage: v + w * t + u x t for the rotation.
    always_comb begin
        side5_next = side4_reg;
        if (side4_reg.func == FUNC_ROT) begin
            side5_next.res[0] = '0;
            for (int i = 0; i < 3; i++) begin
                side5_next.res[1 + i] = sat_word(ACC_W'(b4_reg[i]) + ACC_W'(wt4_reg[i])
                                                 + ACC_W'(x4_reg[i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            func1_reg <= in_data.func;
            for (int i = 0; i < 4; i++) begin
                a1_reg[i]  <= a_in[i];
                b1_reg[i]  <= b_in[i];
                sq1_reg[i] <= a_in[i] * a_in[i];
                for (int j = 0; j < 4; j++) begin
                    p1_reg[i][j] <= a_in[i] * b_in[j];
                end
            end

            side2_reg <= side2_next;
            for (int i = 0; i < 4; i++) begin
                a2_reg[i] <= a1_reg[i];
            end
            for (int i = 0; i < 3; i++) begin
                b2_reg[i] <= b1_reg[1 + i];
                t2_reg[i] <= t2_next[i];
            end

            side3_reg  <= side3_next;
            pt3_reg[0] <= a2_reg[2] * t2_reg[2];
            pt3_reg[1] <= a2_reg[3] * t2_reg[1];
            pt3_reg[2] <= a2_reg[3] * t2_reg[0];
            pt3_reg[3] <= a2_reg[1] * t2_reg[2];
            pt3_reg[4] <= a2_reg[1] * t2_reg[1];
            pt3_reg[5] <= a2_reg[2] * t2_reg[0];
            for (int i = 0; i < 3; i++) begin
                pt3_reg[6 + i] <= a2_reg[0] * t2_reg[i];
                b3_reg[i]      <= b2_reg[i];
            end

            side4_reg <= side3_reg;
            for (int i = 0; i < 3; i++) begin
                b4_reg[i]  <= b3_reg[i];
                x4_reg[i]  <= x4_next[i];
                wt4_reg[i] <= wt4_next[i];
            end

            side5_reg <= side5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_side  = side5_reg;

endmodule

// ===== sv/qau_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root of the squared magnitude, one root bit per stage.
// Depends on qau_pkg.
module qau_sqrt import qau_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  logic         in_valid,
    input  qau_sq_side_t in_side,
    output logic         out_valid,
    output qau_sq_side_t out_side,
    output logic [31:0]  out_root
);

    logic                v_reg    [SQ_STEPS];
    qau_sq_side_t        side_reg [SQ_STEPS];
    logic [31:0]         root_reg [SQ_STEPS], root_next [SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_STEPS], rem_next  [SQ_STEPS];

    logic                v_prev    [SQ_STEPS];
    qau_sq_side_t        side_prev [SQ_STEPS];
    logic [31:0]         root_prev [SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_prev  [SQ_STEPS];
    logic [SQ_REM_W+1:0] cand      [SQ_STEPS];
    logic [SQ_REM_W+1:0] trial     [SQ_STEPS];

    // Each stage brings down the next two bits of the radicand and tries one root bit.
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                v_prev[k]    = in_valid;
                side_prev[k] = in_side;
                root_prev[k] = '0;
                rem_prev[k]  = '0;
            end else begin
                v_prev[k]    = v_reg[k-1];
                side_prev[k] = side_reg[k-1];
                root_prev[k] = root_reg[k-1];
                rem_prev[k]  = rem_reg[k-1];
            end
            cand[k]  = {rem_prev[k], side_prev[k].s[(SQ_STEPS - 1 - k) * 2 +: 2]};
            trial[k] = {2'b00, root_prev[k], 2'b01};
            if (cand[k] >= trial[k]) begin
                rem_next[k]  = SQ_REM_W'(cand[k] - trial[k]);
                root_next[k] = {root_prev[k][30:0], 1'b1};
            end else begin
                rem_next[k]  = SQ_REM_W'(cand[k]);
                root_next[k] = {root_prev[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                v_reg[k] <= v_prev[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                side_reg[k] <= side_prev[k];
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
            end
        end
    end

    assign out_valid = v_reg[SQ_STEPS-1];
    assign out_side  = side_reg[SQ_STEPS-1];
    assign out_root  = root_reg[SQ_STEPS-1];

endmodule

// ===== sv/qau_div.sv =====
`timescale 1ns / 1ps
// Four-lane pipelined restoring divider for normalise and inverse, with the final result select.
// Depends on qau_pkg.
module qau_div import qau_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  logic         in_valid,
    input  qau_sq_side_t in_side,
    input  logic [31:0]  in_root,
    output logic         out_valid,
    output qau_out_t     out_data
);

    logic               pv_reg;
    qau_dv_side_t       pside_reg, pside_next;
    logic [63:0]        pd_reg, pd_next;
    logic [63:0]        prem_reg [4], prem_next [4];
    logic [31:0]        plow_reg [4], plow_next [4];
    logic [NUM_W-1:0]   num [4];
    logic               is_inv;

    logic               v_reg    [DIV_STEPS];
    qau_dv_side_t       side_reg [DIV_STEPS];
    logic [63:0]        d_reg    [DIV_STEPS];
    logic [63:0]        rem_reg  [DIV_STEPS][4], rem_next [DIV_STEPS][4];
    logic [31:0]        low_reg  [DIV_STEPS][4], low_next [DIV_STEPS][4];
    logic [31:0]        q_reg    [DIV_STEPS][4], q_next   [DIV_STEPS][4];

    logic               v_prev    [DIV_STEPS];
    qau_dv_side_t       side_prev [DIV_STEPS];
    logic [63:0]        d_prev    [DIV_STEPS];
    logic [63:0]        rem_prev  [DIV_STEPS][4];
    logic [31:0]        low_prev  [DIV_STEPS][4];
    logic [31:0]        q_prev    [DIV_STEPS][4];
    logic [64:0]        cand      [DIV_STEPS][4];

    logic               fv_reg;
    qau_out_t           fout_reg, fout_next;
    logic [3:0][31:0]   dres;
    qau_dv_side_t       lside;
    logic [31:0]        lq;

    // Numerators: normalise rounds by half the root, inverse by half the squared magnitude.
    // The top part of the numerator seeds the remainder; an inverse whose quotient would
    // reach 2^32 is flagged here and saturated at the end.
    always_comb begin
        is_inv           = (in_side.func == FUNC_INV);
        pside_next.func  = in_side.func;
        pside_next.res   = in_side.res;
        pside_next.fault = in_side.fault;
        pside_next.neg   = in_side.neg;
        pd_next          = is_inv ? in_side.s : 64'(in_root);
        for (int i = 0; i < 4; i++) begin
            if (is_inv) begin
                num[i] = (NUM_W'(in_side.mag[i]) << (2 * FRAC_BITS)) + NUM_W'(in_side.s >> 1);
            end else begin
                num[i] = (NUM_W'(in_side.mag[i]) << FRAC_BITS) + NUM_W'(in_root >> 1);
            end
            prem_next[i]      = 64'(num[i][NUM_W-1:32]);
            plow_next[i]      = num[i][31:0];
            pside_next.big[i] = is_inv && (64'(num[i][NUM_W-1:32]) >= in_side.s);
        end
    end

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                v_prev[k]    = pv_reg;
                side_prev[k] = pside_reg;
                d_prev[k]    = pd_reg;
                for (int i = 0; i < 4; i++) begin
                    rem_prev[k][i] = prem_reg[i];
                    low_prev[k][i] = plow_reg[i];
                    q_prev[k][i]   = '0;
                end
            end else begin
                v_prev[k]    = v_reg[k-1];
                side_prev[k] = side_reg[k-1];
                d_prev[k]    = d_reg[k-1];
                for (int i = 0; i < 4; i++) begin
                    rem_prev[k][i] = rem_reg[k-1][i];
                    low_prev[k][i] = low_reg[k-1][i];
                    q_prev[k][i]   = q_reg[k-1][i];
                end
            end
            for (int i = 0; i < 4; i++) begin
                cand[k][i]     = {rem_prev[k][i], low_prev[k][i][31]};
                low_next[k][i] = {low_prev[k][i][30:0], 1'b0};
                if (cand[k][i] >= {1'b0, d_prev[k]}) begin
                    rem_next[k][i] = 64'(cand[k][i] - {1'b0, d_prev[k]});
                    q_next[k][i]   = {q_prev[k][i][30:0], 1'b1};
                end else begin
                    rem_next[k][i] = cand[k][i][63:0];
                    q_next[k][i]   = {q_prev[k][i][30:0], 1'b0};
                end
            end
        end
    end

    // Final stage: sign and saturate each quotient and pick the result of the operation.
    always_comb begin
        lside = side_reg[DIV_STEPS-1];
        for (int i = 0; i < 4; i++) begin
            lq = q_reg[DIV_STEPS-1][i];
            if (lside.big[i]) begin
                dres[i] = lside.neg[i] ? WORD_MIN : WORD_MAX;
            end else if (lside.neg[i]) begin
                dres[i] = (lq > 32'h8000_0000) ? WORD_MIN : 32'(-lq);
            end else begin
                dres[i] = lq[31] ? WORD_MAX : lq;
            end
        end
        if ((lside.func == FUNC_NORM || lside.func == FUNC_INV) && !lside.fault) begin
            fout_next.r_w = dres[0];
            fout_next.r_x = dres[1];
            fout_next.r_y = dres[2];
            fout_next.r_z = dres[3];
        end else begin
            fout_next.r_w = lside.res[0];
            fout_next.r_x = lside.res[1];
            fout_next.r_y = lside.res[2];
            fout_next.r_z = lside.res[3];
        end
        fout_next.fault = lside.fault;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
            fv_reg <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            pv_reg <= in_valid;
            fv_reg <= v_reg[DIV_STEPS-1];
            for (int k = 0; k < DIV_STEPS; k++) begin
                v_reg[k] <= v_prev[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pside_reg <= pside_next;
            pd_reg    <= pd_next;
            for (int i = 0; i < 4; i++) begin
                prem_reg[i] <= prem_next[i];
                plow_reg[i] <= plow_next[i];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                side_reg[k] <= side_prev[k];
                d_reg[k]    <= d_prev[k];
                for (int i = 0; i < 4; i++) begin
                    rem_reg[k][i] <= rem_next[k][i];
                    low_reg[k][i] <= low_next[k][i];
                    q_reg[k][i]   <= q_next[k][i];
                end
            end
            fout_reg <= fout_next;
        end
    end

    assign out_valid = fv_reg;
    assign out_data  = fout_reg;

endmodule
